@@ sv/cbe_pkg.sv @@
// shared constants, codes and types of the cubic b-spline evaluator
package cbe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_COEFFS = 16;
  localparam int IDX_W      = 4;
  localparam int COEF_W     = 32;
  localparam int CNT_W      = 5;
  localparam int DVS_W      = 31;
  localparam int DIV_W      = COEF_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] REG_KNOT_SPACING = 2'd0;
  localparam logic [1:0] REG_ACTIVE_COUNT = 2'd1;

  localparam logic [DVS_W-1:0] SPACING_RESET = DVS_W'(1 << FRAC_BITS);
  localparam logic [CNT_W-1:0] COUNT_RESET   = CNT_W'(NUM_COEFFS);

  // ceil(2^20 / 6): exact floor(v / 6) for v below 2^19
  localparam logic [17:0] RECIP_SIX   = 18'd174763;
  localparam int          RECIP_SHIFT = 20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_OFFS,
    ST_MSQ,
    ST_MCU,
    ST_MDIV,
    ST_MTERM,
    ST_ACC,
    ST_DONE
  } state_e;

endpackage

@@ sv/cubic_bspline_function_eval.sv @@
// top level: uniform cubic b-spline function evaluator in signed q16.16
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, coeff_index_i,
//   coeff_value_i and sample_i. A transfer with op load writes one table slot
//   and gives no result; a transfer with op evaluate gives one result.
//   Output channel (out_valid_o / out_stall_i) carries result_o and
//   saturated_o, held in an output register.
//   A load writes its table slot at the transfer and leaves the block idle.
//   An evaluation first runs the serial divider (48 quotient bits, then the
//   quotient is taken), then walks the active indices one at a time: an
//   index whose basis is zero takes only the offset step, while each of the
//   at most four nearby indices takes offset, square, cube, divide, term and
//   accumulate steps, all on one shared multiplier, then fills the output
//   register. in_stall_o stays high meanwhile, dropping at the loading edge.
//   A finished result waits in the last step while the output register still
//   holds a stalled result; stalling the output holds the result unchanged.
//   Configuration (knot spacing, active count) is written through cfg_we_i
//   while the block is idle.
//   Reset clears the coefficient table to zero, sets spacing to 1.0 and the
//   active count to 16, and leaves the output channel empty.
module cubic_bspline_function_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [30:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [3:0]          coeff_index_i,
  input  logic signed [31:0]  coeff_value_i,
  input  logic signed [31:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_o,
  output logic                saturated_o
);

  cbe_pkg::state_e state_q, state_d;

  logic [cbe_pkg::DVS_W-1:0]   spacing_q;
  logic [cbe_pkg::CNT_W-1:0]   count_q;
  logic signed [31:0]          coef_q [cbe_pkg::NUM_COEFFS];

  logic                        in_xfer;
  logic                        eval_start;
  logic [31:0]                 sample_mag;
  logic [cbe_pkg::DVS_W-1:0]   divisor;
  logic                        div_done;
  logic [cbe_pkg::DIV_W-1:0]   quotient;

  logic                        neg_q;
  logic signed [31:0]          u_q, u_d;
  logic                        sat_q, sat_d;
  logic [cbe_pkg::IDX_W-1:0]   idx_q;
  logic [cbe_pkg::CNT_W-1:0]   n_q;
  logic [16:0]                 p_q, p_d;
  logic                        inner_q;
  logic [16:0]                 sq_q;
  logic signed [51:0]          prod_q, prod_d;
  logic signed [36:0]          acc_q;

  logic signed [32:0]          t;
  logic [32:0]                 a;
  logic                        near, inner, last;
  logic [16:0]                 pw;
  logic [20:0]                 v_full;
  logic [18:0]                 v;
  logic [16:0]                 basis;
  logic signed [35:0]          term;
  logic signed [32:0]          mul_a;
  logic signed [18:0]          mul_b;
  logic                        q_over;
  logic                        acc_pos_over, acc_neg_over;
  logic signed [31:0]          acc_clip;
  logic                        out_load;
  logic                        step_next;

  assign in_stall_o = (state_q != cbe_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign eval_start = in_xfer && (op_i == cbe_pkg::OP_EVAL);
  assign sample_mag = sample_i[31] ? 32'(-sample_i) : 32'(sample_i);
  assign divisor    = (spacing_q == '0) ? cbe_pkg::DVS_W'(1) : spacing_q;

  cbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eval_start),
    .dividend_i ({sample_mag, cbe_pkg::FRAC_BITS'(0)}),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= cbe_pkg::SPACING_RESET;
      count_q   <= cbe_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cbe_pkg::REG_KNOT_SPACING: spacing_q <= cfg_wdata_i;
        cbe_pkg::REG_ACTIVE_COUNT: count_q <= cfg_wdata_i[cbe_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficient table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cbe_pkg::NUM_COEFFS; k++) coef_q[k] <= '0;
    end else if (in_xfer && (op_i == cbe_pkg::OP_LOAD)) begin
      coef_q[coeff_index_i] <= coeff_value_i;
    end
  end

  // per-index datapath around the shared multiplier
  always_comb begin
    t      = $signed({u_q[31], u_q}) - $signed({13'd0, idx_q, 16'd0});
    a      = t[32] ? 33'(-t) : 33'(t);
    near   = (a[32:17] == '0);
    inner  = (a[32:16] == '0);
    p_d    = inner ? a[16:0] : 17'(18'h20000 - a[17:0]);
    pw     = prod_q[32:16];
    v_full = 21'h40000 - 21'(sq_q) * 21'd6 + 21'(pw) * 21'd3;
    v      = inner_q ? v_full[18:0] : {2'b00, pw};
    basis  = prod_q[36:20];
    term   = prod_q[51:16];
    last   = ({1'b0, idx_q} == (n_q - 1'b1));

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      cbe_pkg::ST_MSQ: begin
        mul_a = $signed({16'd0, p_q});
        mul_b = $signed({2'b00, p_q});
      end
      cbe_pkg::ST_MCU: begin
        mul_a = $signed({16'd0, pw});
        mul_b = $signed({2'b00, p_q});
      end
      cbe_pkg::ST_MDIV: begin
        mul_a = $signed({14'd0, v});
        mul_b = $signed({1'b0, cbe_pkg::RECIP_SIX});
      end
      cbe_pkg::ST_MTERM: begin
        mul_a = $signed({coef_q[idx_q][31], coef_q[idx_q]});
        mul_b = $signed({2'b00, basis});
      end
      default: ;
    endcase
    prod_d = mul_a * mul_b;

    // quotient magnitude to signed 32 bits with clipping
    if (!neg_q) begin
      q_over = |quotient[cbe_pkg::DIV_W-1:31];
      u_d    = q_over ? 32'sh7fffffff : $signed(quotient[31:0]);
    end else begin
      q_over = (|quotient[cbe_pkg::DIV_W-1:32]) || (quotient[31] && (|quotient[30:0]));
      u_d    = q_over ? 32'sh80000000 : $signed(32'(-quotient[31:0]));
    end

    acc_pos_over = !acc_q[36] && (|acc_q[35:31]);
    acc_neg_over = acc_q[36] && !(&acc_q[35:31]);
    if (acc_pos_over)      acc_clip = 32'sh7fffffff;
    else if (acc_neg_over) acc_clip = 32'sh80000000;
    else                   acc_clip = acc_q[31:0];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    out_load  = 1'b0;
    step_next = 1'b0;
    sat_d     = sat_q;
    case (state_q)
      cbe_pkg::ST_IDLE: begin
        if (eval_start) state_d = cbe_pkg::ST_DIV;
      end
      cbe_pkg::ST_DIV: begin
        if (div_done) begin
          sat_d   = q_over;
          state_d = (n_q == '0) ? cbe_pkg::ST_DONE : cbe_pkg::ST_OFFS;
        end
      end
      cbe_pkg::ST_OFFS: begin
        if (near) state_d = cbe_pkg::ST_MSQ;
        else      step_next = 1'b1;
      end
      cbe_pkg::ST_MSQ:   state_d = cbe_pkg::ST_MCU;
      cbe_pkg::ST_MCU:   state_d = cbe_pkg::ST_MDIV;
      cbe_pkg::ST_MDIV:  state_d = cbe_pkg::ST_MTERM;
      cbe_pkg::ST_MTERM: state_d = cbe_pkg::ST_ACC;
      cbe_pkg::ST_ACC:   step_next = 1'b1;
      cbe_pkg::ST_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cbe_pkg::ST_IDLE;
        end
      end
      default: state_d = cbe_pkg::ST_IDLE;
    endcase
    if (step_next) state_d = last ? cbe_pkg::ST_DONE : cbe_pkg::ST_OFFS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbe_pkg::ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sat_q  <= sat_d;
    if (eval_start) begin
      neg_q <= sample_i[31];
      idx_q <= '0;
      acc_q <= '0;
      n_q   <= (count_q > cbe_pkg::CNT_W'(cbe_pkg::NUM_COEFFS))
               ? cbe_pkg::CNT_W'(cbe_pkg::NUM_COEFFS) : count_q;
    end
    if ((state_q == cbe_pkg::ST_DIV) && div_done) u_q <= u_d;
    if (state_q == cbe_pkg::ST_OFFS) begin
      p_q     <= p_d;
      inner_q <= inner;
    end
    if (state_q == cbe_pkg::ST_MCU) sq_q <= pw;
    if (state_q == cbe_pkg::ST_ACC) acc_q <= acc_q + 37'(term);
    if (step_next) idx_q <= idx_q + 1'b1;
    if (out_load) begin
      result_o    <= acc_clip;
      saturated_o <= sat_q || acc_pos_over || acc_neg_over;
    end
  end

endmodule

@@ sv/cbe_div.sv @@
// serial restoring divider, one quotient bit per cycle, unsigned operands
module cbe_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cbe_pkg::DIV_W-1:0]     dividend_i,
  input  logic [cbe_pkg::DVS_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [cbe_pkg::DIV_W-1:0]     quotient_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [cbe_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [cbe_pkg::DVS_W-1:0]         dvs_q, dvs_d;
  logic [cbe_pkg::DVS_W-1:0]         rem_q, rem_d;
  logic [cbe_pkg::DIV_W-1:0]         quo_q, quo_d;
  logic [cbe_pkg::DVS_W:0]           shifted;
  logic [cbe_pkg::DVS_W+1:0]         diff;
  logic                              fits;

  always_comb begin
    shifted = {rem_q, quo_q[cbe_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = ~diff[cbe_pkg::DVS_W+1];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[cbe_pkg::DVS_W-1:0] : shifted[cbe_pkg::DVS_W-1:0];
      quo_d = {quo_q[cbe_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == cbe_pkg::DIV_CNT_W'(cbe_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
